/* hw/rtl/rafq_pkg.sv */
// Shared constants, codes and control types of the room allocator.
`timescale 1ns / 1ps
`default_nettype none

package rafq_pkg;

  // Sizes of the customer map and the room pool
  localparam int unsigned CUSTOMERS = 1024;
  localparam int unsigned ROOMS     = 1024;

  // Word field widths
  localparam int unsigned CUST_W = 10;
  localparam int unsigned ROOM_W = 11;

  // Derived storage widths
  localparam int unsigned MAP_AW  = $clog2(CUSTOMERS);
  localparam int unsigned PTR_W   = $clog2(ROOMS);
  localparam int unsigned FILL_W  = $clog2(ROOMS + 1);
  localparam int unsigned FRESH_W = $clog2(ROOMS + 2);

  // Operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DEPART = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_NO_DEPART = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;   // write zero into the map at the sweep address
    logic accept;  // capture the input word and read the map
    logic commit;  // apply the event and load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;  // sweep is at the last map entry
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/rafq_ctrl.sv */
// Controller state machine: map clearing sweep, accept and commit sequencing.
`timescale 1ns / 1ps
`default_nettype none

module rafq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  rafq_pkg::dp_status_t     status_i,
  output rafq_pkg::ctrl_cmd_t      cmd_o
);
  import rafq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_LOOKUP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Hold the state, start with the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Decide the next state and the commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/rafq_datapath.sv */
// Datapath: customer map, free-room FIFO, counters and output register.
`timescale 1ns / 1ps
`default_nettype none

module rafq_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  rafq_pkg::ctrl_cmd_t                cmd_i,
  output rafq_pkg::dp_status_t               status_o,
  input  wire logic                          operation_i,
  input  wire logic [rafq_pkg::CUST_W-1:0]   customer_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rafq_pkg::ROOM_W-1:0]        room_o,
  output logic [rafq_pkg::ROOM_W-1:0]        rooms_opened_o,
  output logic [1:0]                         status_res_o
);
  import rafq_pkg::*;

  // Memories
  logic [ROOM_W-1:0] map_mem  [CUSTOMERS];
  logic [ROOM_W-1:0] fifo_mem [ROOMS];

  // Control registers
  logic [MAP_AW-1:0]  clr_q;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FRESH_W-1:0] fresh_q, fresh_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers
  logic              op_q;
  logic [CUST_W-1:0] cust_q;
  logic [ROOM_W-1:0] map_rdata_q;
  logic [ROOM_W-1:0] fifo_rdata_q;
  logic [ROOM_W-1:0] room_q, room_d;
  logic [ROOM_W-1:0] opened_q;
  status_e           res_q, res_d;

  // Event decisions
  logic              cust_ok;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic [ROOM_W-1:0] map_wdata;
  logic              upd_we;
  logic [ROOM_W-1:0] upd_data;
  logic              push;

  assign cust_ok = ({{(32-CUST_W){1'b0}}, cust_q} < 32'(CUSTOMERS));

  // Work out the result and the state updates of the held word
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    fresh_d  = fresh_q;
    room_d   = '0;
    res_d    = ST_OK;
    upd_we   = 1'b0;
    upd_data = '0;
    push     = 1'b0;
    if (!cust_ok) begin
      res_d = (op_q == OP_ARRIVE) ? ST_NO_ROOM : ST_NO_DEPART;
    end else if (op_q == OP_ARRIVE) begin
      if (map_rdata_q != '0) begin
        room_d = map_rdata_q;
      end else if (fill_q != '0) begin
        room_d   = fifo_rdata_q;
        rd_ptr_d = (rd_ptr_q == PTR_W'(ROOMS - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
        fill_d   = fill_q - FILL_W'(1);
        upd_we   = 1'b1;
        upd_data = fifo_rdata_q;
      end else if (fresh_q <= FRESH_W'(ROOMS)) begin
        room_d   = ROOM_W'(fresh_q);
        fresh_d  = fresh_q + FRESH_W'(1);
        upd_we   = 1'b1;
        upd_data = ROOM_W'(fresh_q);
      end else begin
        res_d = ST_NO_ROOM;
      end
    end else begin
      if (map_rdata_q == '0) begin
        res_d = ST_NO_DEPART;
      end else begin
        room_d = map_rdata_q;
        upd_we = 1'b1;
        if (fill_q < FILL_W'(ROOMS)) begin
          push     = 1'b1;
          wr_ptr_d = (wr_ptr_q == PTR_W'(ROOMS - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
          fill_d   = fill_q + FILL_W'(1);
        end
      end
    end
  end

  // Select the map write: sweep or event update
  assign map_we    = cmd_i.clear || (cmd_i.commit && upd_we);
  assign map_waddr = cmd_i.clear ? clr_q : MAP_AW'(cust_q);
  assign map_wdata = cmd_i.clear ? '0 : upd_data;

  // Customer map: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd_i.accept) begin
      map_rdata_q <= map_mem[MAP_AW'(customer_i)];
    end
  end

  // Free-room FIFO: push on departure, head read every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && push) begin
      fifo_mem[wr_ptr_q] <= map_rdata_q;
    end
    fifo_rdata_q <= fifo_mem[rd_ptr_q];
  end

  // Capture the input word and load the output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      cust_q <= customer_i;
    end
    if (cmd_i.commit) begin
      room_q   <= room_d;
      opened_q <= ROOM_W'(fresh_d - FRESH_W'(1));
      res_q    <= res_d;
    end
  end

  // Advance the output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold the control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      fresh_q     <= FRESH_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + MAP_AW'(1);
      end
      if (cmd_i.commit) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        fill_q   <= fill_d;
        fresh_q  <= fresh_d;
      end
    end
  end

  assign status_o.clr_last = (clr_q == MAP_AW'(CUSTOMERS - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign room_o         = room_q;
  assign rooms_opened_o = opened_q;
  assign status_res_o   = res_q;

endmodule

`default_nettype wire

/* hw/rtl/room_allocator_free_queue.sv */
// Top level of the room allocator with a queue of freed rooms.
//
// Input channel (in_valid_i / in_ready_o) carries one event word: operation_i
// (0 arrive, 1 depart) and customer_i. Output channel (out_valid_o /
// out_ready_i) returns one word per event: room_o, rooms_opened_o, status_o
// (0 ok, 1 no room left, 2 departure without room).
// Each event takes two steps: one to accept it and read the customer map,
// one to apply it and load the output register. A new event is taken only
// after the last one is applied; the map read and map write-back set this.
// out_valid_o is registered and rises when the event is applied and the
// output register is loaded.
// The output register parts the two channels: a new event is accepted while
// a result still waits, and only its commit stalls while the receiver holds
// out_ready_i low.
// After reset the customer map is cleared, one entry a cycle, over all 1024
// entries (CUSTOMERS); in_ready_o stays low until the sweep ends.
`timescale 1ns / 1ps
`default_nettype none

module room_allocator_free_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [rafq_pkg::CUST_W-1:0]   customer_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rafq_pkg::ROOM_W-1:0]        room_o,
  output logic [rafq_pkg::ROOM_W-1:0]        rooms_opened_o,
  output logic [1:0]                         status_o
);
  import rafq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Sequence the sweep and each event
  rafq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // Hold the map, FIFO, counters and output word
  rafq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .operation_i    (operation_i),
    .customer_i     (customer_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .room_o         (room_o),
    .rooms_opened_o (rooms_opened_o),
    .status_res_o   (status_o)
  );

endmodule

`default_nettype wire
